// ===== sv/spq_pkg.sv =====
// Package for the sorted priority queue: operation and status codes, key function.
// No dependencies; used by spq_cell and the top level.
package spq_pkg;
    typedef enum logic [1:0] {
        FUNC_PEEK  = 2'd0,
        FUNC_PUSH  = 2'd1,
        FUNC_POP   = 2'd2,
        FUNC_CLEAR = 2'd3
    } func_t;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_EMPTY = 2'd2,
        ST_NAN   = 2'd3
    } status_t;

    // Broadcast from the controller to every cell.
    typedef struct packed {
        logic        push;
        logic        pop;
        logic [31:0] key;
        logic [31:0] value;
    } spq_cmd_t;

    function automatic logic is_nan(input logic [31:0] v);
        is_nan = (v[30:23] == 8'hFF) && (v[22:0] != 23'd0);
    endfunction

    // Monotonic unsigned key, -0 folded onto +0.
    function automatic logic [31:0] order_key(input logic [31:0] v);
        logic [31:0] w;
        w = (v == 32'h8000_0000) ? 32'd0 : v;
        order_key = w[31] ? ~w : (w | 32'h8000_0000);
    endfunction
endpackage

// ===== sv/spq_if.sv =====
// Valid/ready channel interface carrying a parameterized payload type.
// Depends on nothing.
interface spq_if #(parameter type payload_t = logic) ();
    logic     valid;
    logic     ready;
    payload_t data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

// ===== sv/spq_cell.sv =====
// One slot of the sorted chain: holds a value and its valid bit.
// Depends on spq_pkg; neighbors feed shift data on push and pop.
module spq_cell (
    input  logic               clk,
    input  logic               rst_n,
    input  spq_pkg::spq_cmd_t  cmd,
    input  logic               clear,
    input  logic               prev_valid,
    input  logic               prev_ins,
    input  logic [31:0]        prev_value,
    input  logic               next_valid,
    input  logic [31:0]        next_value,
    output logic               valid,
    output logic               ins,
    output logic [31:0]        value
);
    import spq_pkg::*;

    logic        valid_reg, valid_next;
    logic [31:0] value_reg, value_next;
    logic        here;

    // Insert at or before this slot when it is empty or its key is not less than the new key.
    // The chain is sorted with empty slots at the tail, so this flag never drops further down.
    assign ins  = ~valid_reg | (order_key(value_reg) >= cmd.key);
    assign here = ins & ~prev_ins & prev_valid;

    always_comb
    begin
        valid_next = valid_reg;
        value_next = value_reg;
        if (clear)
        begin
            valid_next = 1'b0;
        end
        else if (cmd.push)
        begin
            if (prev_ins)
            begin
                valid_next = valid_reg | prev_valid;
                value_next = prev_value;
            end
            else if (here)
            begin
                valid_next = 1'b1;
                value_next = cmd.value;
            end
        end
        else if (cmd.pop)
        begin
            valid_next = next_valid;
            value_next = next_value;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    always_ff @(posedge clk)
    begin
        value_reg <= value_next;
    end

    assign valid = valid_reg;
    assign value = value_reg;
endmodule

// ===== sv/sorted_priority_queue_float_core.sv =====
// Sorted priority queue top level: controller, cell chain, result register.
// Depends on spq_pkg, spq_if and spq_cell.
// Result: registered when the input transfer happens.
// Throughput: one item per cycle while the output is not stalled; the whole cell chain updates together.
// Reset: count and cell valid bits clear asynchronously; stored values are not reset.
module sorted_priority_queue_float_core #(
    parameter int QUEUE_DEPTH = 16
) (
    input  logic clk,
    input  logic rst_n,
    spq_if.sink   in_ch,
    spq_if.source out_ch
);
    import spq_pkg::*;

    localparam int CW = $clog2(QUEUE_DEPTH + 1);

    logic [CW-1:0] count_reg, count_next;
    logic          out_valid_reg;
    logic [39:0]   out_data_reg;
    logic          take;
    logic [1:0]    fn;
    logic [31:0]   pv;
    status_t       st;
    spq_cmd_t      cmd;
    logic          clear;
    logic [31:0]   head;

    logic [QUEUE_DEPTH-1:0] v_out;
    logic [QUEUE_DEPTH-1:0] i_out;
    logic [31:0]           val_out [QUEUE_DEPTH];

    assign in_ch.ready = ~out_valid_reg | out_ch.ready;
    assign take = in_ch.valid & in_ch.ready;
    assign fn = in_ch.data[33:32];
    assign pv = in_ch.data[31:0];

    always_comb
    begin
        st         = ST_OK;
        cmd.push   = 1'b0;
        cmd.pop    = 1'b0;
        cmd.key    = order_key(pv);
        cmd.value  = pv;
        clear      = 1'b0;
        count_next = count_reg;
        unique case (fn)
            FUNC_PEEK:
                if (count_reg == '0) st = ST_EMPTY;
            FUNC_PUSH:
                if (is_nan(pv))
                    st = ST_NAN;
                else if (count_reg == CW'(QUEUE_DEPTH))
                    st = ST_FULL;
                else
                begin
                    cmd.push   = take;
                    count_next = count_reg + 1'b1;
                end
            FUNC_POP:
                if (count_reg == '0)
                    st = ST_EMPTY;
                else
                begin
                    cmd.pop    = take;
                    count_next = count_reg - 1'b1;
                end
            default:
            begin
                clear      = take;
                count_next = '0;
            end
        endcase
    end

    genvar g;
    generate
        for (g = 0; g < QUEUE_DEPTH; g++)
        begin : g_cell
            spq_cell u_cell (
                .clk        (clk),
                .rst_n      (rst_n),
                .cmd        (cmd),
                .clear      (clear),
                .prev_valid (g == 0 ? 1'b1 : v_out[(g == 0) ? 0 : g-1]),
                .prev_ins   (g == 0 ? 1'b0 : i_out[(g == 0) ? 0 : g-1]),
                .prev_value (g == 0 ? pv : val_out[(g == 0) ? 0 : g-1]),
                .next_valid (g == QUEUE_DEPTH-1 ? 1'b0
                             : v_out[(g == QUEUE_DEPTH-1) ? g : g+1]),
                .next_value (g == QUEUE_DEPTH-1 ? 32'd0
                             : val_out[(g == QUEUE_DEPTH-1) ? g : g+1]),
                .valid      (v_out[g]),
                .ins        (i_out[g]),
                .value      (val_out[g])
            );
        end
    endgenerate

    // Head after the operation, computed from the shift rules of slot 0.
    always_comb
    begin
        head = val_out[0];
        if (clear || count_next == '0)
            head = '0;
        else if (cmd.push && i_out[0])
            head = pv;
        else if (cmd.pop)
            head = (QUEUE_DEPTH > 1) ? val_out[(QUEUE_DEPTH > 1) ? 1 : 0] : 32'd0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (take) count_reg <= count_next;
            if (in_ch.ready) out_valid_reg <= in_ch.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
            out_data_reg <= {head, (count_next == '0), 5'(count_next), st};
    end

    assign out_ch.valid = out_valid_reg;
    assign out_ch.data  = out_data_reg;

`ifndef SYNTHESIS
    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(QUEUE_DEPTH)) else $error("count overflow");
    a_head_valid: assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg != '0) == v_out[0]) else $error("head valid mismatch");
    a_empty_top: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_data_reg[7]) |-> (out_data_reg[39:8] == '0))
        else $error("empty with nonzero top");
`endif
endmodule
